// ===== rtl/ebd_pkg.sv =====
// ============================================================================
// ebd_pkg
// Shared types and constants of the eye blink detector.
// ============================================================================
package ebd_pkg;

  // Landmark and ratio number formats.
  localparam int COORD_BITS      = 12;
  localparam int RATIO_FRAC_BITS = 14;
  localparam int PTS_BITS        = 4 * COORD_BITS;
  localparam int RATIO_BITS      = 16;
  localparam int DIST_FRAC       = 8;
  localparam logic [RATIO_BITS-1:0] RATIO_MAX = '1;

  // Configuration register indexes.
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_EAR_THRESHOLD   = 2'd0;
  localparam reg_idx_t REG_COOLDOWN_FRAMES = 2'd1;
  localparam reg_idx_t REG_WINDOW_FRAMES   = 2'd2;

  // One frame of landmarks.
  typedef struct packed {
    logic                face_present;
    logic [PTS_BITS-1:0] left_pts_01;
    logic [PTS_BITS-1:0] left_pts_23;
    logic [PTS_BITS-1:0] left_pts_45;
    logic [PTS_BITS-1:0] right_pts_01;
    logic [PTS_BITS-1:0] right_pts_23;
    logic [PTS_BITS-1:0] right_pts_45;
  } frame_t;

  // One configuration register write.
  typedef struct packed {
    reg_idx_t    index;
    logic [15:0] value;
  } reg_wr_t;

  // One result per frame.
  typedef struct packed {
    logic [RATIO_BITS-1:0] ratio_value;
    logic                  blink_now;
    logic                  eye_shut;
    logic                  window_end;
    logic [7:0]            window_blinks;
    logic [31:0]           blink_total;
  } blink_res_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SQRT,
    ST_DIV,
    ST_EYE_DONE,
    ST_FINISH
  } seq_state_t;

endpackage

// ===== rtl/ebd_stream_if.sv =====
// ============================================================================
// ebd_stream_if
// Valid/ready channel carrying a payload of parameterized type.
// ============================================================================
interface ebd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/ebd_front.sv =====
// ============================================================================
// ebd_front
// Accepts frames and holds them in a two-entry queue for the back end.
// ============================================================================
module ebd_front
  import ebd_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  frame_t in_data,
  output logic   q_valid,
  input  logic   q_pop,
  output frame_t q_data
);
  frame_t     mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_data   = mem[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

// ===== rtl/ebd_back.sv =====
// ============================================================================
// ebd_back
// Computes the eye aspect ratios with a shared root and divide unit and
// updates the blink and window state.
// ============================================================================
module ebd_back
  import ebd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] ear_threshold,
  input  logic [7:0]  cooldown_frames,
  input  logic [7:0]  window_frames,
  input  logic        q_valid,
  output logic        q_pop,
  input  frame_t      q_data,
  output logic        out_valid,
  input  logic        out_ready,
  output blink_res_t  out_data
);
  // Squared distance shifted by 16 fits in SQ_BITS; root is half that.
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int MAG_BITS   = COORD_BITS;
  localparam int SUMSQ_BITS = 2 * MAG_BITS + 1;
  localparam int SQ_BITS    = SUMSQ_BITS + 2 * DIST_FRAC;
  localparam int SQ_W       = SQ_BITS + (SQ_BITS % 2);
  localparam int RT_BITS    = SQ_W / 2;
  localparam int NUM_BITS   = RT_BITS + 1;
  localparam int DEN_BITS   = RT_BITS + 1;
  localparam int SAT_SHIFT  = RATIO_BITS - RATIO_FRAC_BITS;
  localparam int RT_CNT_W   = $clog2(RT_BITS);
  localparam int DV_CNT_W   = $clog2(RATIO_BITS);

  seq_state_t state, state_next;

  logic                  eye;        // 0 left, 1 right
  logic [1:0]            dsel;       // 0: p1-p5, 1: p2-p4, 2: p0-p3
  logic [SQ_W-1:0]       sq;
  logic [RT_BITS+1:0]    rem;
  logic [RT_BITS-1:0]    root;
  logic [RT_CNT_W-1:0]   step;
  logic [NUM_BITS-1:0]   num;
  logic [RT_BITS-1:0]    dist_c;
  logic [DEN_BITS-1:0]   drem;
  logic [RATIO_BITS-1:0] dlow;
  logic [RATIO_BITS-1:0] quo;
  logic [DV_CNT_W-1:0]   dstep;
  logic [RATIO_BITS:0]   ratio_sum;

  // Window and blink state.
  logic        closed_flag;
  logic [7:0]  cooldown_left;
  logic [7:0]  blinks_in_window;
  logic [7:0]  frames_in_window;
  logic [31:0] total_count;

  // Coordinate extraction.
  function automatic logic signed [DIFF_BITS-1:0] crd(
    input logic [PTS_BITS-1:0] f, input int slot);
    logic [COORD_BITS-1:0] raw;
    raw = f[(3-slot)*COORD_BITS +: COORD_BITS];
    return DIFF_BITS'(signed'(raw));
  endfunction

  logic [PTS_BITS-1:0]         f01, f23, f45;
  logic signed [DIFF_BITS-1:0] ax, ay, bx, by, dx, dy, adx, ady;
  logic [2*MAG_BITS-1:0]       mx, my, sqx, sqy;
  logic [SUMSQ_BITS-1:0]       sumsq;

  // Squared distance of the point pair picked by eye and dsel.
  always_comb begin
    f01 = eye ? q_data.right_pts_01 : q_data.left_pts_01;
    f23 = eye ? q_data.right_pts_23 : q_data.left_pts_23;
    f45 = eye ? q_data.right_pts_45 : q_data.left_pts_45;
    unique case (dsel)
      2'd0: begin
        ax = crd(f01, 2); ay = crd(f01, 3); bx = crd(f45, 2); by = crd(f45, 3);
      end
      2'd1: begin
        ax = crd(f23, 0); ay = crd(f23, 1); bx = crd(f45, 0); by = crd(f45, 1);
      end
      default: begin
        ax = crd(f01, 0); ay = crd(f01, 1); bx = crd(f23, 2); by = crd(f23, 3);
      end
    endcase
    dx  = ax - bx;
    dy  = ay - by;
    adx = dx[DIFF_BITS-1] ? -dx : dx;
    ady = dy[DIFF_BITS-1] ? -dy : dy;
    mx  = {{MAG_BITS{1'b0}}, adx[MAG_BITS-1:0]};
    my  = {{MAG_BITS{1'b0}}, ady[MAG_BITS-1:0]};
    sqx = mx * mx;
    sqy = my * my;
    sumsq = {1'b0, sqx} + {1'b0, sqy};
  end

  // Bitwise root step, two radicand bits per cycle.
  logic [RT_BITS+3:0] rem_hi, trial, rem_sub;
  logic               rt_take;
  logic [RT_BITS-1:0] root_nx;
  logic [RT_BITS+1:0] rem_nx;

  always_comb begin
    rem_hi  = {rem, sq[SQ_W-1 -: 2]};
    trial   = {2'b00, root, 2'b01};
    rem_sub = rem_hi - trial;
    rt_take = (rem_hi >= trial);
    root_nx = {root[RT_BITS-2:0], rt_take};
    rem_nx  = rt_take ? rem_sub[RT_BITS+1:0] : rem_hi[RT_BITS+1:0];
  end

  // Restoring divide step, one quotient bit per cycle.
  logic [DEN_BITS:0]   dshift, dden, dsub;
  logic                dv_take;
  logic [DEN_BITS-1:0] drem_nx;

  always_comb begin
    dshift  = {drem, dlow[RATIO_BITS-1]};
    dden    = {1'b0, dist_c, 1'b0};
    dsub    = dshift - dden;
    dv_take = (dshift >= dden);
    drem_nx = dv_take ? dsub[DEN_BITS-1:0] : dshift[DEN_BITS-1:0];
  end

  // Eye ratio: saturate on zero width or an overflowing quotient.
  logic [RATIO_BITS-1:0] eye_ratio;

  always_comb begin
    if (dist_c == '0 ||
        {{SAT_SHIFT{1'b0}}, num} >= {dist_c, {(SAT_SHIFT+1){1'b0}}}) begin
      eye_ratio = RATIO_MAX;
    end else begin
      eye_ratio = quo;
    end
  end

  // Blink and window update for the frame being finished.
  logic [RATIO_BITS-1:0] mean;
  logic                  face;
  logic                  out_free;
  logic                  blink_hit;
  logic                  closed_nx;
  logic [7:0]            cool_base;
  logic [7:0]            cool_nx;
  logic [7:0]            blinks_nx;
  logic [7:0]            frames_inc;
  logic                  wend;
  logic [32:0]           tsum;
  logic [31:0]           total_nx;

  always_comb begin
    mean      = ratio_sum[RATIO_BITS:1];
    face      = q_data.face_present;
    out_free  = !out_valid || out_ready;
    blink_hit = face && (mean < ear_threshold) && !closed_flag &&
                (cooldown_left == 8'd0);
    if (blink_hit) begin
      closed_nx = 1'b1;
    end else if (face && mean >= ear_threshold) begin
      closed_nx = 1'b0;
    end else begin
      closed_nx = closed_flag;
    end
    cool_base = blink_hit ? cooldown_frames : cooldown_left;
    if (face) begin
      cool_nx = (cool_base != 8'd0) ? cool_base - 8'd1 : 8'd0;
    end else begin
      cool_nx = cooldown_left;
    end
    blinks_nx  = (blink_hit && blinks_in_window != 8'hFF) ? blinks_in_window + 8'd1
                                                         : blinks_in_window;
    frames_inc = frames_in_window + 8'd1;
    wend       = (frames_inc == window_frames);
    tsum       = {1'b0, total_count} + {25'd0, blinks_nx};
    if (wend) begin
      total_nx = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
    end else begin
      total_nx = total_count;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) state_next = face ? ST_LOAD : ST_FINISH;
      end
      ST_LOAD:     state_next = ST_SQRT;
      ST_SQRT: begin
        if (step == '0) state_next = (dsel == 2'd2) ? ST_DIV : ST_LOAD;
      end
      ST_DIV: begin
        if (dstep == '0) state_next = ST_EYE_DONE;
      end
      ST_EYE_DONE: state_next = eye ? ST_FINISH : ST_LOAD;
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  // Output logic of the sequencer.
  always_comb begin
    q_pop = (state == ST_FINISH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result valid and frame state.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid        <= 1'b0;
      closed_flag      <= 1'b0;
      cooldown_left    <= '0;
      blinks_in_window <= '0;
      frames_in_window <= '0;
      total_count      <= '0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid        <= 1'b1;
      closed_flag      <= closed_nx;
      cooldown_left    <= cool_nx;
      blinks_in_window <= wend ? 8'd0 : blinks_nx;
      frames_in_window <= wend ? 8'd0 : frames_inc;
      total_count      <= total_nx;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        eye       <= 1'b0;
        dsel      <= 2'd0;
        num       <= '0;
        ratio_sum <= '0;
      end
      ST_LOAD: begin
        sq   <= {{(SQ_W-SQ_BITS){1'b0}}, sumsq, {(2*DIST_FRAC){1'b0}}};
        rem  <= '0;
        root <= '0;
        step <= RT_CNT_W'(RT_BITS - 1);
      end
      ST_SQRT: begin
        rem  <= rem_nx;
        root <= root_nx;
        sq   <= {sq[SQ_W-3:0], 2'b00};
        if (step != '0) begin
          step <= step - 1'b1;
        end else if (dsel == 2'd2) begin
          // Width done: set up the divide.
          dist_c <= root_nx;
          drem   <= num >> SAT_SHIFT;
          dlow   <= {num[SAT_SHIFT-1:0], {RATIO_FRAC_BITS{1'b0}}};
          quo    <= '0;
          dstep  <= DV_CNT_W'(RATIO_BITS - 1);
        end else begin
          num  <= num + {1'b0, root_nx};
          dsel <= dsel + 2'd1;
        end
      end
      ST_DIV: begin
        drem <= drem_nx;
        quo  <= {quo[RATIO_BITS-2:0], dv_take};
        dlow <= {dlow[RATIO_BITS-2:0], 1'b0};
        if (dstep != '0) dstep <= dstep - 1'b1;
      end
      ST_EYE_DONE: begin
        ratio_sum <= ratio_sum + {1'b0, eye_ratio};
        eye       <= 1'b1;
        dsel      <= 2'd0;
        num       <= '0;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_data.ratio_value   <= face ? mean : '0;
          out_data.blink_now     <= blink_hit;
          out_data.eye_shut      <= closed_nx;
          out_data.window_end    <= wend;
          out_data.window_blinks <= wend ? blinks_nx : 8'd0;
          out_data.blink_total   <= total_nx;
        end
      end
      default: ;
    endcase
  end
endmodule

// ===== rtl/eye_blink_detector_core.sv =====
// ============================================================================
// eye_blink_detector_core
// Eye aspect ratio blink detector with windowed blink counting.
// ============================================================================
// One frame in, one result out, in order. A two-entry queue takes frames while
// the back end works on one frame at a time. For a face frame the back end
// starts, then for each eye loads and takes the root of three distances (two
// radicand bits per cycle), computes the quotient bit by bit and folds in
// the ratio, then posts the result. A frame without a face goes straight from
// the start to posting the result. The shared bitwise root and restoring
// divider do this work. The back end waits to post its result while a previous
// result is still held by a low out_ch.ready. Configuration
// writes take effect at once and belong between frames.
module eye_blink_detector_core
  import ebd_pkg::*;
(
  input logic clk,
  input logic rst,
  ebd_stream_if.sink   in_ch,
  ebd_stream_if.sink   cfg_ch,
  ebd_stream_if.source out_ch
);
  logic [15:0] ear_threshold;
  logic [7:0]  cooldown_frames;
  logic [7:0]  window_frames;

  // Configuration register writes.
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      ear_threshold   <= 16'd4096;
      cooldown_frames <= 8'd10;
      window_frames   <= 8'd30;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.data.index)
        REG_EAR_THRESHOLD:   ear_threshold   <= cfg_ch.data.value[15:0];
        REG_COOLDOWN_FRAMES: cooldown_frames <= cfg_ch.data.value[7:0];
        REG_WINDOW_FRAMES:   window_frames   <= cfg_ch.data.value[7:0];
        default: ;
      endcase
    end
  end

  logic   q_valid, q_pop;
  frame_t q_data;

  ebd_front u_front (
    .clk, .rst,
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_data  (in_ch.data),
    .q_valid, .q_pop, .q_data
  );

  ebd_back u_back (
    .clk, .rst,
    .ear_threshold, .cooldown_frames, .window_frames,
    .q_valid, .q_pop, .q_data,
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
  );
endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Self-checking bench for the eye blink detector core. Frames go in through a
// queue-fed driver, results are checked against an in-bench predictor of the
// eye aspect ratio, blink and window counting behavior.
// ============================================================================
module testbench;
  import ebd_pkg::*;

  localparam int COORD_W    = COORD_BITS;
  localparam int FRAC_W     = RATIO_FRAC_BITS;
  localparam int STALL_MAX  = 3000;
  localparam int SETTLE_CYC = 400;

  logic clk;
  logic rst;

  ebd_stream_if #(.payload_t(frame_t))     in_ch ();
  ebd_stream_if #(.payload_t(reg_wr_t))    cfg_ch ();
  ebd_stream_if #(.payload_t(blink_res_t)) out_ch ();

  eye_blink_detector_core u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  // Predictor state and register copies.
  logic [15:0] thr_q;
  logic [7:0]  cool_reload_q;
  logic [7:0]  win_len_q;
  logic        shut_q;
  logic [7:0]  cool_left_q;
  logic [7:0]  win_blinks_q;
  logic [7:0]  win_frames_q;
  logic [31:0] total_q;

  frame_t     frame_queue[$];
  blink_res_t expected_results[$];
  int         error_count = 0;
  bit         calm = 0;
  bit         in_taken = 0;
  int         in_gap = 0;
  int         out_gap = 0;
  int         stall_cycles = 0;

  task automatic report(input string msg);
    $display("%s", msg);
    error_count++;
  endtask

  // Append one frame to the pending queue.
  task automatic add_frame(input frame_t f);
    frame_queue.insert(frame_queue.size(), f);
  endtask

  // Integer square root, bit by bit.
  function automatic longint unsigned int_root(input longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n    = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic longint coord(input logic [PTS_BITS-1:0] f, input int slot);
    logic signed [COORD_W-1:0] c;
    c = f[(3 - slot) * COORD_W +: COORD_W];
    return longint'(c);
  endfunction

  function automatic longint unsigned span(input longint xa, input longint ya,
                                           input longint xb, input longint yb);
    longint unsigned dx;
    longint unsigned dy;
    dx = (xa > xb) ? xa - xb : xb - xa;
    dy = (ya > yb) ? ya - yb : yb - ya;
    return int_root((dx * dx + dy * dy) << (2 * DIST_FRAC));
  endfunction

  // Aspect ratio of one eye in Q2.14, saturated.
  function automatic longint unsigned aspect(input logic [PTS_BITS-1:0] f01,
                                             input logic [PTS_BITS-1:0] f23,
                                             input logic [PTS_BITS-1:0] f45);
    longint px[6];
    longint py[6];
    longint unsigned num;
    longint unsigned den;
    px[0] = coord(f01, 0); py[0] = coord(f01, 1);
    px[1] = coord(f01, 2); py[1] = coord(f01, 3);
    px[2] = coord(f23, 0); py[2] = coord(f23, 1);
    px[3] = coord(f23, 2); py[3] = coord(f23, 3);
    px[4] = coord(f45, 0); py[4] = coord(f45, 1);
    px[5] = coord(f45, 2); py[5] = coord(f45, 3);
    num = span(px[1], py[1], px[5], py[5]) + span(px[2], py[2], px[4], py[4]);
    den = 2 * span(px[0], py[0], px[3], py[3]);
    if (den == 0) return 64'hFFFF;
    if (num >= (den << (16 - FRAC_W))) return 64'hFFFF;
    return (num << FRAC_W) / den;
  endfunction

  // Advance the predictor by one frame and return its expected result.
  function automatic blink_res_t predict_frame(input frame_t fr);
    blink_res_t r;
    longint unsigned mean;
    r = '0;
    if (fr.face_present) begin
      mean = (aspect(fr.left_pts_01, fr.left_pts_23, fr.left_pts_45) +
              aspect(fr.right_pts_01, fr.right_pts_23, fr.right_pts_45)) >> 1;
      r.ratio_value = mean[15:0];
      if (mean < thr_q && !shut_q && cool_left_q == 0) begin
        shut_q = 1'b1;
        if (win_blinks_q != 8'hFF) win_blinks_q++;
        cool_left_q = cool_reload_q;
        r.blink_now = 1'b1;
      end else if (mean >= thr_q) begin
        shut_q = 1'b0;
      end
      if (cool_left_q != 0) cool_left_q--;
    end
    win_frames_q = win_frames_q + 8'd1;
    if (win_frames_q == win_len_q) begin
      r.window_end    = 1'b1;
      r.window_blinks = win_blinks_q;
      if ({1'b0, total_q} + win_blinks_q > 33'hFFFF_FFFF) total_q = '1;
      else total_q = total_q + win_blinks_q;
      win_blinks_q = '0;
      win_frames_q = '0;
    end
    r.eye_shut    = shut_q;
    r.blink_total = total_q;
    return r;
  endfunction

  function automatic logic [PTS_BITS-1:0] pack_pts(input longint xa, input longint ya,
                                                   input longint xb, input longint yb);
    logic [COORD_W-1:0] a;
    logic [COORD_W-1:0] b;
    logic [COORD_W-1:0] c;
    logic [COORD_W-1:0] d;
    a = xa[COORD_W-1:0]; b = ya[COORD_W-1:0];
    c = xb[COORD_W-1:0]; d = yb[COORD_W-1:0];
    return {a, b, c, d};
  endfunction

  // Six contour points of a plausible eye; openness h against half width w.
  function automatic logic [3*PTS_BITS-1:0] eye_shape(input longint cx, input longint cy,
                                                      input longint w, input longint h);
    longint t;
    t = w / 3;
    return {pack_pts(cx - w, cy, cx - t, cy - h),
            pack_pts(cx + t, cy - h, cx + w, cy),
            pack_pts(cx + t, cy + h, cx - t, cy + h)};
  endfunction

  function automatic logic [PTS_BITS-1:0] rand_pts();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[PTS_BITS-1:0];
  endfunction

  function automatic frame_t noise_frame();
    frame_t f;
    f.face_present = 1'($urandom_range(0, 1));
    f.left_pts_01  = rand_pts();
    f.left_pts_23  = rand_pts();
    f.left_pts_45  = rand_pts();
    f.right_pts_01 = rand_pts();
    f.right_pts_23 = rand_pts();
    f.right_pts_45 = rand_pts();
    return f;
  endfunction

  function automatic frame_t face_frame(input longint w, input longint h);
    frame_t f;
    longint cx;
    longint cy;
    longint hr;
    cx = longint'($urandom_range(0, 3000)) - 1500;
    cy = longint'($urandom_range(0, 3000)) - 1500;
    hr = h + longint'($urandom_range(0, 2)) - 1;
    if (hr < 0) hr = 0;
    f.face_present = 1'b1;
    {f.left_pts_01, f.left_pts_23, f.left_pts_45}    = eye_shape(cx - 2 * w, cy, w, h);
    {f.right_pts_01, f.right_pts_23, f.right_pts_45} = eye_shape(cx + 2 * w, cy, w, hr);
    return f;
  endfunction

  // Random frames, mostly open and closing eye sequences.
  task automatic queue_random(input int count);
    frame_t f;
    longint w;
    int k;
    int run;
    bit closing;
    k = 0;
    closing = 0;
    while (k < count) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          add_frame(noise_frame());
          k++;
        end
        2: begin
          f = face_frame(40, 10);
          f.face_present = 1'b0;
          add_frame(f);
          k++;
        end
        default: begin
          w = $urandom_range(4, 200);
          run = $urandom_range(1, 6);
          for (int i = 0; i < run; i++) begin
            if (closing) add_frame(face_frame(w, $urandom_range(0, w / 5)));
            else add_frame(face_frame(w, $urandom_range(w / 5, w)));
            k++;
          end
          closing = !closing;
        end
      endcase
    end
  endtask

  task automatic queue_directed();
    frame_t f;
    f = '0;
    f.face_present = 1'b1;
    add_frame(f);
    f.face_present = 1'b0;
    add_frame(f);
    f = '1;
    add_frame(f);
    // Widest eye and extreme corners.
    f.face_present = 1'b1;
    f.left_pts_01  = pack_pts(-2048, -2048, -2048, 2047);
    f.left_pts_23  = pack_pts(2047, -2048, 2047, 2047);
    f.left_pts_45  = pack_pts(2047, 2047, -2048, -2048);
    f.right_pts_01 = pack_pts(2047, 2047, 0, 0);
    f.right_pts_23 = pack_pts(0, 0, -2048, -2048);
    f.right_pts_45 = pack_pts(-2048, 2047, 2047, -2048);
    add_frame(f);
    f.left_pts_01  = pack_pts(-2048, 0, -2048, 2047);
    f.left_pts_23  = pack_pts(2047, 2047, -2048, 0);
    add_frame(f);
    add_frame(face_frame(100, 0));
    add_frame(face_frame(100, 0));
    add_frame(face_frame(100, 80));
    add_frame(face_frame(100, 5));
    add_frame(face_frame(3, 300));
    add_frame(face_frame(600, 0));
    for (int i = 0; i < 6; i++) add_frame(noise_frame());
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.data.index <= idx;
    cfg_ch.data.value <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_EAR_THRESHOLD:   thr_q         = val;
      REG_COOLDOWN_FRAMES: cool_reload_q = val[7:0];
      REG_WINDOW_FRAMES:   win_len_q     = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Let the queued frames drain, then allow the block to go quiet.
  task automatic drain();
    do @(posedge clk);
    while (frame_queue.size() != 0 || in_ch.valid || expected_results.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_regs(input logic [15:0] thr, input logic [7:0] cool,
                          input logic [7:0] win);
    write_reg(REG_EAR_THRESHOLD, thr);
    write_reg(REG_COOLDOWN_FRAMES, {8'd0, cool});
    write_reg(REG_WINDOW_FRAMES, {8'd0, win});
  endtask

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stimulus sequencing.
  initial begin
    thr_q         = 16'd4096;
    cool_reload_q = 8'd10;
    win_len_q     = 8'd30;
    shut_q        = 1'b0;
    cool_left_q   = '0;
    win_blinks_q  = '0;
    win_frames_q  = '0;
    total_q       = '0;
    rst           = 1'b1;
    cfg_ch.valid  = 1'b0;
    cfg_ch.data   = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    queue_directed();
    queue_random(170);
    drain();
    set_regs(16'hFFFF, 8'd0, 8'd1);
    queue_random(150);
    drain();
    set_regs(16'd0, 8'd255, 8'd255);
    queue_random(150);
    drain();
    set_regs(16'($urandom_range(1000, 9000)), 8'($urandom_range(1, 6)),
             8'($urandom_range(2, 40)));
    queue_random(200);
    drain();
    set_regs(16'd4096, 8'd3, 8'd7);
    calm = 1'b1;
    queue_random(250);
    drain();

    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Frame driver: pops the queue at the falling edge, with random gaps.
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      expected_results.insert(expected_results.size(), predict_frame(in_ch.data));
      in_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
    end else if (in_taken || !in_ch.valid) begin
      in_taken = 1'b0;
      if (in_gap == 0 && !calm && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 17);
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (frame_queue.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.data  <= frame_queue.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result ready with random stall bursts.
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_gap == 0 && !calm && $urandom_range(0, 7) == 0) out_gap = $urandom_range(1, 17);
      if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Result monitor and checker.
  always @(posedge clk) begin
    blink_res_t exp_r;
    blink_res_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (expected_results.size() == 0) begin
        report("tb: result transfer with nothing expected");
      end else begin
        exp_r = expected_results.pop_front();
        if (got.ratio_value !== exp_r.ratio_value)
          report($sformatf("ratio_value got %0d want %0d", got.ratio_value,
                           exp_r.ratio_value));
        if (got.blink_now !== exp_r.blink_now)
          report($sformatf("blink_now got %0b want %0b", got.blink_now, exp_r.blink_now));
        if (got.eye_shut !== exp_r.eye_shut)
          report($sformatf("eye_shut got %0b want %0b", got.eye_shut, exp_r.eye_shut));
        if (got.window_end !== exp_r.window_end)
          report($sformatf("window_end got %0b want %0b", got.window_end,
                           exp_r.window_end));
        if (got.window_blinks !== exp_r.window_blinks)
          report($sformatf("window_blinks got %0d want %0d", got.window_blinks,
                           exp_r.window_blinks));
        if (got.blink_total !== exp_r.blink_total)
          report($sformatf("blink_total got %0d want %0d", got.blink_total,
                           exp_r.blink_total));
      end
    end
  end

  // Watchdog on cycles with no transfer on any channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || rst) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_MAX) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
